// ===== rtl/opa_pkg.sv =====
`default_nettype none

package opa_pkg;

    // Limits on the effective step and path counts.
    localparam int unsigned MAX_STEPS = 4096;
    localparam int unsigned MAX_PATHS = 1048576;

    // Field and accumulator widths.
    localparam int unsigned PRICE_W = 32;
    localparam int unsigned STEP_W  = 13;
    localparam int unsigned PATH_W  = 21;
    localparam int unsigned SUM_W   = 44;
    localparam int unsigned KS_W    = 45;
    localparam int unsigned ATOT_W  = 64;
    localparam int unsigned BTOT_W  = 52;

    // Divider widths: dividend/quotient and divisor.
    localparam int unsigned DVD_W   = 64;
    localparam int unsigned DVS_W   = 21;

    // Configuration register indexes (byte address divided by four).
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_STRIKE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BARRIER   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STEPS     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PATHS     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DISCOUNT  = 3'd4;

    // Register reset values.
    localparam logic [PRICE_W-1:0] STRIKE_RST   = 32'd6553600;
    localparam logic [PRICE_W-1:0] BARRIER_RST  = 32'd5898240;
    localparam logic [STEP_W-1:0]  STEPS_RST    = 13'd252;
    localparam logic [PATH_W-1:0]  PATHS_RST    = 21'd1000000;
    localparam logic [PRICE_W-1:0] DISCOUNT_RST = 32'd4085499175;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DIV_GO,
        S_DIV_A,
        S_DIV_B,
        S_DIV_C,
        S_SCA_LO,
        S_SCA_HI,
        S_SCA_SUM,
        S_SCB_LO,
        S_SCB_HI,
        S_SCB_SUM,
        S_OUT
    } state_t;

    // Operand selection of the shared divider.
    typedef enum logic [1:0] {
        DIV_ASIAN_STEPS,
        DIV_ASIAN_PATHS,
        DIV_BARRIER_PATHS
    } div_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     take_sample;
        logic     mul;
        logic     acc;
        logic     div_start;
        div_sel_t div_sel;
        logic     latch_qa;
        logic     latch_qb;
        logic     scl_lo;
        logic     scl_hi;
        logic     scl_sum;
        logic     scale_sel;
        logic     load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic path_end;
        logic run_end;
        logic div_done;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/option_payoff_accumulator_top.sv =====
// Samples inside a path are taken one per cycle while the controller is idle; none is
// taken while the last sample of a path is accumulated. At the end of a run the result
// follows three quotients of the bit-serial divider and the discount scaling.
// The result waits in an output register, so the next run's samples are taken meanwhile.
// Reset returns the configuration registers to their defaults and clears the path and run totals.
`default_nettype none

module option_payoff_accumulator_top
    import opa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // Input stream: [31:0] price
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [31:0]       s_axis_tdata,
    // Result stream: [31:0] average-payoff price, [63:32] knock-out price
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [63:0]       m_axis_tdata,
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    logic [PRICE_W-1:0] strike_reg;
    logic [PRICE_W-1:0] barrier_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic [PATH_W-1:0]  paths_reg;
    logic [PRICE_W-1:0] discount_reg;
    logic               cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;
    cmd_t               cmd;
    status_t            status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[ADDR_W-1:2];

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strike_reg   <= STRIKE_RST;
            barrier_reg  <= BARRIER_RST;
            steps_reg    <= STEPS_RST;
            paths_reg    <= PATHS_RST;
            discount_reg <= DISCOUNT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_STRIKE:   strike_reg   <= pwdata;
                REG_BARRIER:  barrier_reg  <= pwdata;
                REG_STEPS:    steps_reg    <= pwdata[STEP_W-1:0];
                REG_PATHS:    paths_reg    <= pwdata[PATH_W-1:0];
                REG_DISCOUNT: discount_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    // Configuration register reads.
    always_comb
    begin
        case (cfg_idx)
            REG_STRIKE:   prdata = strike_reg;
            REG_BARRIER:  prdata = barrier_reg;
            REG_STEPS:    prdata = 32'(steps_reg);
            REG_PATHS:    prdata = 32'(paths_reg);
            REG_DISCOUNT: prdata = discount_reg;
            default:      prdata = '0;
        endcase
    end

    opa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    opa_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .strike        (strike_reg),
        .barrier_level (barrier_reg),
        .step_count    (steps_reg),
        .path_count    (paths_reg),
        .discount      (discount_reg),
        .price         (s_axis_tdata),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .avg_result    (m_axis_tdata[31:0]),
        .ko_result     (m_axis_tdata[63:32])
    );

    // A finished result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded while previous result still pending");

    // The divider is only started when it is idle or just finishing.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (!status.div_busy || status.div_done))
        else $error("divider restarted while busy");

    // A result becomes valid only after the controller loads it.
    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.load_out))
        else $error("result valid without a load");

endmodule

`default_nettype wire

// ===== rtl/opa_div.sv =====
`default_nettype none

module opa_div
    import opa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output logic                  busy,
    output logic                  done
);

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] work_reg, work_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   rem_shift;
    logic             fits;

    // One restoring step per cycle: the quotient bits shift in as the dividend shifts out.
    always_comb
    begin
        rem_shift = {rem_reg, work_reg[DVD_W-1]};
        fits      = rem_shift >= {1'b0, dvs_reg};
        rem_next  = fits ? DVS_W'(rem_shift - {1'b0, dvs_reg}) : DVS_W'(rem_shift);
        work_next = {work_reg[DVD_W-2:0], fits};
        cnt_next  = cnt_reg - CNT_W'(1);
        done_next = busy && (cnt_reg == CNT_W'(1));
    end

    assign busy     = cnt_reg != '0;
    assign quotient = work_reg;
    assign done     = done_reg;

    // Iteration counter and completion flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (start)
            begin
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (busy)
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

    // Partial remainder and shifting dividend/quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/opa_ctrl.sv =====
`default_nettype none

module opa_ctrl
    import opa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    cmd.take_sample = 1'b1;
                    if (status.path_end)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.run_end ? S_DIV_GO : S_IDLE;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ASIAN_STEPS;
                state_next    = S_DIV_A;
            end
            S_DIV_A:
            begin
                if (status.div_done)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_ASIAN_PATHS;
                    state_next    = S_DIV_B;
                end
            end
            S_DIV_B:
            begin
                if (status.div_done)
                begin
                    cmd.latch_qa  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_BARRIER_PATHS;
                    state_next    = S_DIV_C;
                end
            end
            S_DIV_C:
            begin
                if (status.div_done)
                begin
                    cmd.latch_qb = 1'b1;
                    state_next   = S_SCA_LO;
                end
            end
            S_SCA_LO:
            begin
                cmd.scl_lo = 1'b1;
                state_next = S_SCA_HI;
            end
            S_SCA_HI:
            begin
                cmd.scl_hi = 1'b1;
                state_next = S_SCA_SUM;
            end
            S_SCA_SUM:
            begin
                cmd.scl_sum = 1'b1;
                state_next  = S_SCB_LO;
            end
            S_SCB_LO:
            begin
                cmd.scale_sel = 1'b1;
                cmd.scl_lo    = 1'b1;
                state_next    = S_SCB_HI;
            end
            S_SCB_HI:
            begin
                cmd.scale_sel = 1'b1;
                cmd.scl_hi    = 1'b1;
                state_next    = S_SCB_SUM;
            end
            S_SCB_SUM:
            begin
                cmd.scale_sel = 1'b1;
                cmd.scl_sum   = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/opa_dpath.sv =====
`default_nettype none

module opa_dpath
    import opa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic [PRICE_W-1:0] strike,
    input  wire logic [PRICE_W-1:0] barrier_level,
    input  wire logic [STEP_W-1:0]  step_count,
    input  wire logic [PATH_W-1:0]  path_count,
    input  wire logic [PRICE_W-1:0] discount,
    input  wire logic [PRICE_W-1:0] price,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic      [PRICE_W-1:0] avg_result,
    output logic      [PRICE_W-1:0] ko_result
);

    // Path and run state.
    logic [STEP_W-1:0]  pos_reg;
    logic [SUM_W-1:0]   path_sum_reg;
    logic               ko_reg;
    logic [PRICE_W-1:0] last_price_reg;
    logic [PATH_W-1:0]  paths_done_reg;
    logic [ATOT_W-1:0]  asian_total_reg;
    logic [BTOT_W-1:0]  barrier_total_reg;
    logic [KS_W-1:0]    ks_reg;

    // Final computation.
    logic [DVD_W-1:0]   qa_reg;
    logic [BTOT_W-1:0]  qb_reg;
    logic [2*PRICE_W-1:0] prod_reg;
    logic [PRICE_W-1:0] acc_reg;
    logic [PRICE_W-1:0] asian_res_reg;
    logic [PRICE_W-1:0] barrier_res_reg;

    // Output register.
    logic               out_valid_reg;
    logic [PRICE_W-1:0] out_asian_reg;
    logic [PRICE_W-1:0] out_barrier_reg;

    logic [STEP_W-1:0]  steps_eff;
    logic [PATH_W-1:0]  paths_eff;
    logic [SUM_W:0]     sum_add;
    logic [SUM_W-1:0]   path_sum_next;
    logic [KS_W-1:0]    asian_diff;
    logic [ATOT_W:0]    atot_add;
    logic [PRICE_W-1:0] bar_diff;
    logic [BTOT_W:0]    btot_add;
    logic [PATH_W-1:0]  paths_inc;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic [DVD_W-1:0]   div_quot;
    logic               div_busy;
    logic               div_done;
    logic [DVD_W-1:0]   scl_op;
    logic [2*PRICE_W-1:0] scl_total;
    logic [PRICE_W-1:0] scl_res;

    // Effective counts: zero counts as one, large values clamp to the maximum.
    always_comb
    begin
        if (step_count == '0)
            steps_eff = STEP_W'(1);
        else if (step_count > STEP_W'(MAX_STEPS))
            steps_eff = STEP_W'(MAX_STEPS);
        else
            steps_eff = step_count;
        if (path_count == '0)
            paths_eff = PATH_W'(1);
        else if (path_count > PATH_W'(MAX_PATHS))
            paths_eff = PATH_W'(MAX_PATHS);
        else
            paths_eff = path_count;
    end

    // Per-sample sum with saturation; the start price is not summed.
    always_comb
    begin
        sum_add = {1'b0, path_sum_reg} + (SUM_W + 1)'(price);
        if (pos_reg == '0)
            path_sum_next = path_sum_reg;
        else if (sum_add[SUM_W])
            path_sum_next = '1;
        else
            path_sum_next = sum_add[SUM_W-1:0];
    end

    // Path-end payoffs added to the run totals.
    always_comb
    begin
        asian_diff = {1'b0, path_sum_reg} - ks_reg;
        atot_add   = {1'b0, asian_total_reg} + (ATOT_W + 1)'(asian_diff);
        bar_diff   = last_price_reg - strike;
        btot_add   = {1'b0, barrier_total_reg} + (BTOT_W + 1)'(bar_diff);
        paths_inc  = paths_done_reg + PATH_W'(1);
    end

    assign status.path_end = pos_reg >= steps_eff;
    assign status.run_end  = (paths_inc == '0) || (paths_inc >= paths_eff);
    assign status.div_done = div_done;
    assign status.div_busy = div_busy;
    assign status.out_free = !out_valid_reg || out_ready;

    // Sample, path and run state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            path_sum_reg      <= '0;
            ko_reg            <= 1'b0;
            paths_done_reg    <= '0;
            asian_total_reg   <= '0;
            barrier_total_reg <= '0;
        end
        else
        begin
            if (cmd.take_sample)
            begin
                path_sum_reg <= path_sum_next;
                if (price < barrier_level)
                    ko_reg <= 1'b1;
                if (!status.path_end)
                    pos_reg <= pos_reg + STEP_W'(1);
            end
            else if (cmd.acc)
            begin
                if ({1'b0, path_sum_reg} > ks_reg)
                    asian_total_reg <= atot_add[ATOT_W] ? '1 : atot_add[ATOT_W-1:0];
                if (!ko_reg && (last_price_reg > strike))
                    barrier_total_reg <= btot_add[BTOT_W] ? '1 : btot_add[BTOT_W-1:0];
                pos_reg        <= '0;
                path_sum_reg   <= '0;
                ko_reg         <= 1'b0;
                paths_done_reg <= status.run_end ? '0 : paths_inc;
            end
            else if (cmd.load_out)
            begin
                asian_total_reg   <= '0;
                barrier_total_reg <= '0;
            end
        end
    end

    // Last sample of the path and the strike-times-steps product.
    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
            last_price_reg <= price;
        if (cmd.mul)
            ks_reg <= KS_W'(strike) * KS_W'(steps_eff);
    end

    // Divider operand selection.
    always_comb
    begin
        case (cmd.div_sel)
            DIV_ASIAN_STEPS:
            begin
                div_dvd = asian_total_reg;
                div_dvs = DVS_W'(steps_eff);
            end
            DIV_ASIAN_PATHS:
            begin
                div_dvd = div_quot;
                div_dvs = paths_eff;
            end
            DIV_BARRIER_PATHS:
            begin
                div_dvd = DVD_W'(barrier_total_reg);
                div_dvs = paths_eff;
            end
            default:
            begin
                div_dvd = '0;
                div_dvs = paths_eff;
            end
        endcase
    end

    opa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quot),
        .busy     (div_busy),
        .done     (div_done)
    );

    // Discount scaling: low half product, high half product, then the sum.
    always_comb
    begin
        scl_op    = cmd.scale_sel ? DVD_W'(qb_reg) : qa_reg;
        scl_total = prod_reg + (2 * PRICE_W)'(acc_reg);
        scl_res   = (scl_total[2*PRICE_W-1:PRICE_W] != '0) ? '1 : scl_total[PRICE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_qa)
            qa_reg <= div_quot;
        if (cmd.latch_qb)
            qb_reg <= div_quot[BTOT_W-1:0];
        if (cmd.scl_lo)
        begin
            prod_reg <= (2 * PRICE_W)'(scl_op[PRICE_W-1:0]) * (2 * PRICE_W)'(discount);
        end
        if (cmd.scl_hi)
        begin
            acc_reg  <= prod_reg[2*PRICE_W-1:PRICE_W];
            prod_reg <= (2 * PRICE_W)'(scl_op[DVD_W-1:PRICE_W]) * (2 * PRICE_W)'(discount);
        end
        if (cmd.scl_sum)
        begin
            if (cmd.scale_sel)
                barrier_res_reg <= scl_res;
            else
                asian_res_reg <= scl_res;
        end
        if (cmd.load_out)
        begin
            out_asian_reg   <= asian_res_reg;
            out_barrier_reg <= barrier_res_reg;
        end
    end

    // Result valid flag; a new result loads only when the slot is free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid  = out_valid_reg;
    assign avg_result = out_asian_reg;
    assign ko_result  = out_barrier_reg;

endmodule

`default_nettype wire

// ===== dv/option_payoff_accumulator_top_test.sv =====
`timescale 1ns / 100ps

module option_payoff_accumulator_top_test;
    import opa_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 400;
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned PHASES        = 24;

    // One result transfer: the Asian price in the low word, the knock-out price in the high word.
    typedef struct packed {
        logic [31:0] barrier;
        logic [31:0] asian;
    } price_pair_t;

    typedef struct packed {
        logic [31:0]       strike;
        logic [31:0]       barrier;
        logic [STEP_W-1:0] steps;
        logic [PATH_W-1:0] paths;
        logic [31:0]       discount;
    } pricing_cfg_t;

    // One directed sample; the prices are filled in only for run ends worked out by hand.
    typedef struct packed {
        logic [31:0] price;
        logic        typed;
        logic [31:0] asian;
        logic [31:0] barrier;
    } directed_row_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [63:0]       m_axis_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    // Register copies kept by the predictor.
    logic [31:0]       cur_strike   = STRIKE_RST;
    logic [31:0]       cur_barrier  = BARRIER_RST;
    logic [STEP_W-1:0] cur_steps    = STEPS_RST;
    logic [PATH_W-1:0] cur_paths    = PATHS_RST;
    logic [31:0]       cur_discount = DISCOUNT_RST;

    // Path and run state kept by the predictor.
    logic [STEP_W-1:0] sample_pos    = '0;
    logic [SUM_W-1:0]  path_sum      = '0;
    logic              path_broken   = 1'b0;
    logic [PATH_W-1:0] paths_seen    = '0;
    logic [ATOT_W-1:0] asian_total   = '0;
    logic [BTOT_W-1:0] barrier_total = '0;

    price_pair_t expected_prices[$];
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    bit          quiet_mode  = 1'b0;

    // Strike 100.0, barrier 90.0, one step, one path, discount one half.
    directed_row_t directed_rows [14] = '{
        '{32'h0064_0000, 1'b0, 32'h0, 32'h0},
        '{32'h006E_0000, 1'b1, 32'h0005_0000, 32'h0005_0000},
        '{32'h0050_0000, 1'b0, 32'h0, 32'h0},
        '{32'h0078_0000, 1'b1, 32'h000A_0000, 32'h0000_0000},
        '{32'h0064_0000, 1'b0, 32'h0, 32'h0},
        '{32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0},
        '{32'hFFFF_FFFF, 1'b1, 32'h7FCD_FFFF, 32'h7FCD_FFFF},
        '{32'h005A_0000, 1'b0, 32'h0, 32'h0},
        '{32'h0065_0000, 1'b1, 32'h0000_8000, 32'h0000_8000},
        '{32'h0064_0000, 1'b0, 32'h0, 32'h0},
        '{32'h0059_FFFF, 1'b1, 32'h0000_0000, 32'h0000_0000},
        '{32'h0064_0000, 1'b0, 32'h0, 32'h0},
        '{32'h0064_0000, 1'b1, 32'h0000_0000, 32'h0000_0000}
    };

    option_payoff_accumulator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock with a 2 ns period.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // floor(m * discount / 2^32), saturated to 32 bits.
    function automatic logic [31:0] discount_scale(input logic [63:0] m);
        logic [95:0] prod;
        prod = 96'(m) * 96'(cur_discount);
        return (prod[95:64] != '0) ? 32'hFFFF_FFFF : prod[63:32];
    endfunction

    // Advance the path and run state by one sample; returns 1 when a run ends.
    function automatic bit accumulate_sample(input logic [31:0] p, output price_pair_t res);
        int unsigned steps_eff;
        int unsigned paths_eff;
        logic [KS_W-1:0] ks;
        logic [SUM_W:0]  s_ext;
        logic [ATOT_W:0] a_ext;
        logic [BTOT_W:0] b_ext;
        logic [63:0]     asian_mean;

        steps_eff = (cur_steps == 0) ? 1 : ((cur_steps > MAX_STEPS) ? MAX_STEPS : cur_steps);
        paths_eff = (cur_paths == 0) ? 1 : ((cur_paths > MAX_PATHS) ? MAX_PATHS : cur_paths);

        if (p < cur_barrier)
            path_broken = 1'b1;
        if (sample_pos != 0)
        begin
            s_ext    = (SUM_W+1)'(path_sum) + (SUM_W+1)'(p);
            path_sum = s_ext[SUM_W] ? '1 : s_ext[SUM_W-1:0];
        end
        if (sample_pos < steps_eff)
        begin
            sample_pos = sample_pos + 1'b1;
            return 1'b0;
        end

        // Path end: add both payoffs to the run totals.
        ks = KS_W'(64'(cur_strike) * 64'(steps_eff));
        if (path_sum > ks)
        begin
            a_ext       = (ATOT_W+1)'(asian_total) + (ATOT_W+1)'(path_sum) - (ATOT_W+1)'(ks);
            asian_total = a_ext[ATOT_W] ? '1 : a_ext[ATOT_W-1:0];
        end
        if (!path_broken && p > cur_strike)
        begin
            b_ext         = (BTOT_W+1)'(barrier_total) + (BTOT_W+1)'(p)
                            - (BTOT_W+1)'(cur_strike);
            barrier_total = b_ext[BTOT_W] ? '1 : b_ext[BTOT_W-1:0];
        end
        sample_pos  = '0;
        path_sum    = '0;
        path_broken = 1'b0;
        paths_seen  = paths_seen + 1'b1;
        if (paths_seen != 0 && paths_seen < paths_eff)
            return 1'b0;

        // Run end: average, discount and clear the totals.
        asian_mean    = (asian_total / 64'(steps_eff)) / 64'(paths_eff);
        res.asian     = discount_scale(asian_mean);
        res.barrier   = discount_scale(64'(barrier_total) / 64'(paths_eff));
        paths_seen    = '0;
        asian_total   = '0;
        barrier_total = '0;
        return 1'b1;
    endfunction

    // Mostly short gaps, a few long ones, none in quiet stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly prices around the strike, sometimes the extremes or anything at all.
    function automatic logic [31:0] draw_price();
        int unsigned r;
        logic [32:0] offset;
        logic [32:0] up;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 32'h0;
        if (r < 6)
            return 32'hFFFF_FFFF;
        if (r < 12)
            return $urandom;
        offset = 33'($urandom_range(0, 32'h0018_0000));
        if ($urandom_range(0, 1) == 1)
        begin
            up = 33'(cur_strike) + offset;
            return up[32] ? 32'hFFFF_FFFF : up[31:0];
        end
        return (33'(cur_strike) < offset) ? 32'h0 : cur_strike - offset[31:0];
    endfunction

    function automatic pricing_cfg_t random_setting();
        pricing_cfg_t c;
        logic [31:0] below;
        case ($urandom_range(0, 9))
            0:       c.strike = 32'h0;
            1:       c.strike = 32'hFFFF_FFFF;
            2, 3:    c.strike = $urandom;
            default: c.strike = $urandom_range(32'h0010_0000, 32'h0400_0000);
        endcase
        below = $urandom_range(0, 32'h0020_0000);
        case ($urandom_range(0, 9))
            0:       c.barrier = 32'h0;
            1:       c.barrier = 32'hFFFF_FFFF;
            2:       c.barrier = $urandom;
            default: c.barrier = (c.strike < below) ? 32'h0 : c.strike - below;
        endcase
        c.steps = ($urandom_range(0, 9) == 0) ? STEP_W'($urandom_range(10, 40))
                                              : STEP_W'($urandom_range(0, 6));
        c.paths = ($urandom_range(0, 7) == 0) ? PATH_W'($urandom_range(8, 20))
                                              : PATH_W'($urandom_range(0, 5));
        case ($urandom_range(0, 9))
            0:       c.discount = 32'h0;
            1:       c.discount = 32'hFFFF_FFFF;
            default: c.discount = $urandom_range(32'hC000_0000, 32'hFFFF_FFFF);
        endcase
        return c;
    endfunction

    // Configuration write: setup phase, then access phase until pready, then psel drops.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_STRIKE:   cur_strike   = value;
            REG_BARRIER:  cur_barrier  = value;
            REG_STEPS:    cur_steps    = value[STEP_W-1:0];
            REG_PATHS:    cur_paths    = value[PATH_W-1:0];
            REG_DISCOUNT: cur_discount = value;
            default:      ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_setting(input pricing_cfg_t c);
        write_reg(REG_STRIKE, c.strike);
        write_reg(REG_BARRIER, c.barrier);
        write_reg(REG_STEPS, 32'(c.steps));
        write_reg(REG_PATHS, 32'(c.paths));
        write_reg(REG_DISCOUNT, c.discount);
    endtask

    // Hold the input stream until every pending price has come out.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_prices.size() != 0);
    endtask

    // Drain, then give a run end still in the divider time to finish.
    task automatic wait_idle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One sample transfer; its run-end prices, if any, join the queue.
    task automatic send_price(input logic [31:0] p, input bit typed, input price_pair_t typed_val);
        int unsigned gap;
        price_pair_t predicted;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (accumulate_sample(p, predicted))
            expected_prices.push_back(typed ? typed_val : predicted);
        @(negedge clk);
    endtask

    task automatic run_phase(input pricing_cfg_t c, input int unsigned n_items,
                             input bit quiet, input bit pause_midway);
        wait_idle();
        program_setting(c);
        quiet_mode = quiet;
        for (int unsigned k = 0; k < n_items; k++)
        begin
            if ((pause_midway && k == n_items / 2) || $urandom_range(0, 199) == 0)
                hold_until_drained();
            send_price(draw_price(), 1'b0, '0);
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s mismatch at cycle %0d: expected %h, got %h",
                     field, cycle_count, want, got);
    endtask

    // Result side: random back-pressure, quiet stretches stay ready.
    initial
    begin
        int unsigned stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Compare each result transfer with the oldest pending prices.
    always @(posedge clk)
    begin : result_check
        price_pair_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_prices.size() == 0)
                report_mismatch("unexpected result", 32'h0, m_axis_tdata[31:0]);
            else
            begin
                want = expected_prices.pop_front();
                if (m_axis_tdata[31:0] !== want.asian)
                    report_mismatch("average price", want.asian, m_axis_tdata[31:0]);
                if (m_axis_tdata[63:32] !== want.barrier)
                    report_mismatch("knock-out price", want.barrier, m_axis_tdata[63:32]);
            end
        end
    end

    // Main sequence: reset, directed table, then randomized phases.
    initial
    begin
        pricing_cfg_t c;
        int unsigned  n_items;
        bit           quiet;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed part: one step, one path per run, discount one half.
        c.strike   = 32'h0064_0000;
        c.barrier  = 32'h005A_0000;
        c.steps    = STEP_W'(1);
        c.paths    = PATH_W'(1);
        c.discount = 32'h8000_0000;
        program_setting(c);
        foreach (directed_rows[i])
            send_price(directed_rows[i].price, directed_rows[i].typed,
                       '{barrier: directed_rows[i].barrier, asian: directed_rows[i].asian});

        // Random phases; some leave a path or a run open across the next setting.
        for (int unsigned ph = 0; ph < PHASES; ph++)
        begin
            c       = random_setting();
            n_items = $urandom_range(40, 120);
            quiet   = ($urandom_range(0, 4) == 0);
            case (ph)
                3:
                begin
                    // Zero counts are taken as one.
                    c.steps = '0;
                    c.paths = '0;
                end
                7:
                begin
                    // Longest path left open; the next setting cuts it short.
                    c.steps = STEP_W'(MAX_STEPS);
                    n_items = 30;
                end
                10:
                begin
                    // Run left open at the largest path count; the next setting ends it.
                    c.steps = STEP_W'(2);
                    c.paths = '1;
                    n_items = 40;
                end
                15:
                begin
                    // Step count above the limit; the path stays open and the next setting
                    // cuts it short.
                    c.steps = '1;
                    c.paths = PATH_W'(1);
                    n_items = 60;
                    quiet   = 1'b1;
                end
                default: ;
            endcase
            run_phase(c, n_items, quiet, (ph % 6) == 2);
        end

        // Wind down and report.
        quiet_mode = 1'b0;
        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
